// ===== sv/sapi_pkg.sv =====
// ----------------------------------------------------------------------------
// sapi_pkg
// Shared constants, types and helpers for the sensor array peak interpolator.
// ----------------------------------------------------------------------------
package sapi_pkg;

    // Active strings (3 or 4); sample and threshold slots are always four wide
    localparam int STRING_COUNT = 4;
    localparam int SLOT_COUNT   = 4;
    localparam int IDX_W        = 2;

    localparam int SAMPLE_W     = 16;
    localparam int VALUE_W      = 7;
    localparam int POS_W        = 8;

    // step = span / (STRING_COUNT - 1) is at most 63, and every share is <= step
    localparam int STEP_W       = 6;
    localparam int DVD_W        = SAMPLE_W + STEP_W;

    // Divider: quotient bits retired per pipeline stage
    localparam int DIV_STAGES   = 3;
    localparam int DIV_BITS     = STEP_W / DIV_STAGES;

    // Reciprocal for span / (STRING_COUNT - 1), exact for 7-bit span
    localparam int RECIP_SHIFT  = 9;
    localparam int RECIP_MULT   = ((1 << RECIP_SHIFT) + STRING_COUNT - 2) / (STRING_COUNT - 1);
    localparam int PROD_W       = VALUE_W + RECIP_SHIFT;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STRING_COUNT - 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN  = 3'd6;

    localparam logic [VALUE_W-1:0] BASE_RESET = 7'd0;
    localparam logic [VALUE_W-1:0] TOP_RESET  = 7'd127;
    localparam logic [VALUE_W-1:0] SPAN_RESET = 7'd127;

    typedef struct packed {
        logic [SLOT_COUNT-1:0][SAMPLE_W-1:0] thr;
        logic [VALUE_W-1:0]                  base;
        logic [VALUE_W-1:0]                  top;
        logic [STEP_W-1:0]                   step;
    } sapi_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] pk;
        logic             pk_act;
        logic             lo_act;
        logic             hi_act;
    } sapi_meta_t;

    typedef struct packed {
        sapi_meta_t          meta;
        logic [SAMPLE_W-1:0] divisor;
        logic [DVD_W-1:0]    rem_lo;
        logic [DVD_W-1:0]    rem_hi;
        logic [STEP_W-1:0]   q_lo;
        logic [STEP_W-1:0]   q_hi;
    } sapi_div_t;

    function automatic logic [STEP_W-1:0] span_to_step(logic [VALUE_W-1:0] span);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(span) * PROD_W'(RECIP_MULT);
        return STEP_W'(prod >> RECIP_SHIFT);
    endfunction

endpackage

// ===== sv/sapi_cfg.sv =====
// ----------------------------------------------------------------------------
// sapi_cfg
// Configuration register file; keeps step precomputed from span.
// ----------------------------------------------------------------------------
module sapi_cfg import sapi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    output sapi_cfg_t            cfg
);

    logic [SLOT_COUNT-1:0][SAMPLE_W-1:0] thr_reg, thr_next;
    logic [VALUE_W-1:0]                  base_reg, base_next;
    logic [VALUE_W-1:0]                  top_reg, top_next;
    logic [STEP_W-1:0]                   step_reg, step_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        thr_next  = thr_reg;
        base_next = base_reg;
        top_next  = top_reg;
        step_next = step_reg;
        if (cfg_valid) begin
            unique case (cfg_index) inside
                CFG_THR_0, CFG_THR_1, CFG_THR_2, CFG_THR_3: begin
                    thr_next[cfg_index[IDX_W-1:0]] = cfg_data;
                end
                CFG_BASE: base_next = cfg_data[VALUE_W-1:0];
                CFG_TOP:  top_next  = cfg_data[VALUE_W-1:0];
                CFG_SPAN: step_next = span_to_step(cfg_data[VALUE_W-1:0]);
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= '0;
            base_reg <= BASE_RESET;
            top_reg  <= TOP_RESET;
            step_reg <= span_to_step(SPAN_RESET);
        end else begin
            thr_reg  <= thr_next;
            base_reg <= base_next;
            top_reg  <= top_next;
            step_reg <= step_next;
        end
    end

    assign cfg.thr  = thr_reg;
    assign cfg.base = base_reg;
    assign cfg.top  = top_reg;
    assign cfg.step = step_reg;

endmodule

// ===== sv/sapi_front.sv =====
// ----------------------------------------------------------------------------
// sapi_front
// Peak search and threshold tests, then neighbor select and share multiply.
// ----------------------------------------------------------------------------
module sapi_front import sapi_pkg::*; (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sapi_cfg_t                           cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [SLOT_COUNT-1:0][SAMPLE_W-1:0] in_samples,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sapi_div_t                           out_item
);

    // stage A: peak index and activity flags
    logic                                a_valid_reg;
    logic [SLOT_COUNT-1:0][SAMPLE_W-1:0] a_smp_reg;
    logic [IDX_W-1:0]                    a_pk_reg, a_pk_next;
    logic [SLOT_COUNT-1:0]               a_act_reg, a_act_next;
    logic [SAMPLE_W-1:0]                 best;
    logic                                a_ready;

    // stage B: dividends ready for the divider
    logic      b_valid_reg;
    sapi_div_t b_item_reg, b_item_next;
    logic      b_ready;

    logic [IDX_W-1:0]    lo_idx, hi_idx;

    always_comb begin
        best      = in_samples[0];
        a_pk_next = '0;
        // first index wins on a tie: strict compare only
        for (int i = 1; i < STRING_COUNT; i++) begin
            if (in_samples[i] > best) begin
                best      = in_samples[i];
                a_pk_next = IDX_W'(i);
            end
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            a_act_next[i] = in_samples[i] > cfg.thr[i];
        end
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        lo_idx = a_pk_reg - 1'b1;
        hi_idx = a_pk_reg + 1'b1;
        b_item_next.meta.pk     = a_pk_reg;
        b_item_next.meta.pk_act = a_act_reg[a_pk_reg];
        b_item_next.meta.lo_act = (a_pk_reg != '0) && a_act_reg[lo_idx];
        b_item_next.meta.hi_act = (a_pk_reg != LAST_IDX) && a_act_reg[hi_idx];
        b_item_next.divisor     = a_smp_reg[a_pk_reg];
        b_item_next.rem_lo      = DVD_W'(a_smp_reg[lo_idx]) * DVD_W'(cfg.step);
        b_item_next.rem_hi      = DVD_W'(a_smp_reg[hi_idx]) * DVD_W'(cfg.step);
        b_item_next.q_lo        = '0;
        b_item_next.q_hi        = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg <= in_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_smp_reg <= in_samples;
            a_pk_reg  <= a_pk_next;
            a_act_reg <= a_act_next;
        end
        if (b_ready) begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

// ===== sv/sapi_divider.sv =====
// ----------------------------------------------------------------------------
// sapi_divider
// Pipelined restoring divider for both neighbor shares, DIV_BITS per stage.
// ----------------------------------------------------------------------------
module sapi_divider import sapi_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  sapi_div_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output sapi_div_t out_item
);

    logic                  v_reg [DIV_STAGES];
    sapi_div_t             item_reg [DIV_STAGES];
    sapi_div_t             item_next [DIV_STAGES];
    logic                  up_valid [DIV_STAGES];
    sapi_div_t             up_item [DIV_STAGES];
    logic [DIV_STAGES-1:0] rdy;

    // Quotient fits in STEP_W bits, so remainder < divisor << (bit + 1)
    // holds at every step and a plain compare/subtract suffices.
    function automatic sapi_div_t div_step(sapi_div_t it, int stage);
        sapi_div_t        r;
        logic [DVD_W-1:0] sub;
        r = it;
        for (int j = 0; j < DIV_BITS; j++) begin
            sub = DVD_W'(r.divisor) << (STEP_W - 1 - stage * DIV_BITS - j);
            if (r.rem_lo >= sub) begin
                r.rem_lo = r.rem_lo - sub;
                r.q_lo   = {r.q_lo[STEP_W-2:0], 1'b1};
            end else begin
                r.q_lo   = {r.q_lo[STEP_W-2:0], 1'b0};
            end
            if (r.rem_hi >= sub) begin
                r.rem_hi = r.rem_hi - sub;
                r.q_hi   = {r.q_hi[STEP_W-2:0], 1'b1};
            end else begin
                r.q_hi   = {r.q_hi[STEP_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                up_valid[k] = in_valid;
                up_item[k]  = in_item;
            end else begin
                up_valid[k] = v_reg[k-1];
                up_item[k]  = item_reg[k-1];
            end
            item_next[k] = div_step(up_item[k], k);
        end
    end

    always_comb begin
        rdy[DIV_STAGES-1] = !v_reg[DIV_STAGES-1] || out_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= up_valid[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (rdy[k]) begin
                item_reg[k] <= item_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_item  = item_reg[DIV_STAGES-1];

endmodule

// ===== sv/sensor_array_peak_interpolator.sv =====
// ----------------------------------------------------------------------------
// sensor_array_peak_interpolator
// Finds the strongest sensing string in a frame and interpolates a position.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one frame per transaction, four 16-bit strain samples.
//   m_* channel: one 8-bit position per frame, in frame order.
//   cfg_* channel: register writes (index 0..3 thresholds, 4 base, 5 top, 6 span);
//     always ready. The user must write only while the pipe is empty; the
//     block itself does not enforce it.
// Pipeline: peak search, neighbor multiply, three divider stages, output register.
// Throughput: one frame per cycle while the output is not stalled; the divider
//   retires two quotient bits per stage so a new frame can enter every cycle.
// Reset: all valid bits clear, registers return to their reset values
//   (thresholds 0, base 0, top 127, span 127).
// Stall: ready passes back combinationally through all stages; a stalled result holds in
//   the output register while upstream bubbles still fill, and s_ready drops
//   only when every stage holds a frame.
// ----------------------------------------------------------------------------
module sensor_array_peak_interpolator import sapi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    // frame input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SAMPLE_W-1:0]  s_sample_0,
    input  logic [SAMPLE_W-1:0]  s_sample_1,
    input  logic [SAMPLE_W-1:0]  s_sample_2,
    input  logic [SAMPLE_W-1:0]  s_sample_3,
    // position output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [POS_W-1:0]     m_position_value
);

    sapi_cfg_t                           cfg;
    logic [SLOT_COUNT-1:0][SAMPLE_W-1:0] samples;

    logic      fr_valid, fr_ready;
    sapi_div_t fr_item;
    logic      dv_valid, dv_ready;
    sapi_div_t dv_item;

    logic             m_valid_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] anchor;
    logic [POS_W-1:0] lo_share, hi_share;

    assign samples = {s_sample_3, s_sample_2, s_sample_1, s_sample_0};

    sapi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // peak search + neighbor * step (two stages)
    sapi_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_samples (samples),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .out_item   (fr_item)
    );

    // (neighbor * step) / peak for both neighbors
    sapi_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_item  (dv_item)
    );

    // Final combine. End strings anchor on base/top; inner strings on
    // pk * step + base. Lower share subtracts, upper adds, all mod 256.
    // lo_act/hi_act are already cleared where the neighbor does not exist.
    always_comb begin
        if (dv_item.meta.pk == '0) begin
            anchor = POS_W'(cfg.base);
        end else if (dv_item.meta.pk == LAST_IDX) begin
            anchor = POS_W'(cfg.top);
        end else begin
            anchor = POS_W'(POS_W'(dv_item.meta.pk) * POS_W'(cfg.step)) + POS_W'(cfg.base);
        end
        lo_share = dv_item.meta.lo_act ? POS_W'(dv_item.q_lo) : '0;
        hi_share = dv_item.meta.hi_act ? POS_W'(dv_item.q_hi) : '0;
        if (!dv_item.meta.pk_act) begin
            pos_next = POS_W'(cfg.base);   // nothing pressed
        end else begin
            pos_next = anchor - lo_share + hi_share;
        end
    end

    // output register: holds the position; m_ready feeds the pipe's ready directly
    assign dv_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dv_ready) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (dv_ready) begin
            pos_reg <= pos_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_position_value = pos_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks sensor_array_peak_interpolator against its own position predictor.
// Frames are queued per configuration phase (directed corners first, then
// shaped random frames), driven with random gaps, and every position
// is compared in order with the predicted one. The receiver also stalls at
// random and once holds off long enough to back the pipe up to the input.
// ----------------------------------------------------------------------------
module tb;
    import sapi_pkg::*;

    // four sample slots, slot 0 in the low bits
    typedef logic [SLOT_COUNT-1:0][SAMPLE_W-1:0] slot_vec_t;

    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_FRAMES   = 220;
    localparam int DRAIN_CYCLES   = 16;    // settle time after the last position
    localparam int HOLD_AT        = 560;   // early in the third random phase
    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_FROM     = 1000;  // no gaps on either side in this window
    localparam int QUIET_TO       = 1200;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 cfg_valid        = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [SAMPLE_W-1:0]  cfg_data         = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_sample_0       = '0;
    logic [SAMPLE_W-1:0]  s_sample_1       = '0;
    logic [SAMPLE_W-1:0]  s_sample_2       = '0;
    logic [SAMPLE_W-1:0]  s_sample_3       = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [POS_W-1:0]     m_position_value;

    // register shadow used by the predictor
    int unsigned thr_q [SLOT_COUNT];
    int unsigned base_q = 32'(BASE_RESET);
    int unsigned top_q  = 32'(TOP_RESET);
    int unsigned span_q = 32'(SPAN_RESET);

    slot_vec_t        pending_frames [$];
    logic [POS_W-1:0] expected_positions [$];
    slot_vec_t        next_frame;
    logic [POS_W-1:0] oldest_position;

    int  frames_issued   = 0;
    int  frames_accepted = 0;
    int  mismatches      = 0;
    int  quiet_cycles    = 0;
    logic hold_off       = 1'b0;

    sensor_array_peak_interpolator i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_0       (s_sample_0),
        .s_sample_1       (s_sample_1),
        .s_sample_2       (s_sample_2),
        .s_sample_3       (s_sample_3),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position_value (m_position_value)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) thr_q[i] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Position predictor
    // Strongest string wins, lowest index on a tie. Nothing above threshold
    // gives base. End strings start from base / top; interior strings from
    // index * step + base. Each neighbor above its threshold moves the
    // result by neighbor * step / peak. Everything wraps to 8 bits.
    // ------------------------------------------------------------------------
    function automatic logic [POS_W-1:0] predict_position(slot_vec_t f);
        int unsigned s [SLOT_COUNT];
        int unsigned pk;
        int unsigned last;
        int unsigned step;
        int unsigned r;
        for (int i = 0; i < SLOT_COUNT; i++) s[i] = 32'(f[i]);
        last = STRING_COUNT - 1;
        step = span_q / (STRING_COUNT - 1);
        pk   = 0;
        for (int i = 1; i < STRING_COUNT; i++)
            if (s[i] > s[pk]) pk = i;
        if (!(s[pk] > thr_q[pk])) begin
            r = base_q;
        end else if (pk == 0) begin
            r = base_q;
            if (s[1] > thr_q[1]) r += s[1] * step / s[0];
        end else if (pk == last) begin
            // may go below zero; the 32-bit wrap keeps the low byte right
            r = top_q;
            if (s[last-1] > thr_q[last-1]) r -= s[last-1] * step / s[last];
        end else begin
            r = pk * step + base_q;
            if (s[pk-1] > thr_q[pk-1]) r -= s[pk-1] * step / s[pk];
            if (s[pk+1] > thr_q[pk+1]) r += s[pk+1] * step / s[pk];
        end
        return r[POS_W-1:0];
    endfunction

    // random gaps on both sides, except inside the quiet window
    function automatic bit take_gap();
        if (frames_accepted >= QUIET_FROM && frames_accepted < QUIET_TO) return 1'b0;
        return $urandom_range(99) < 14;
    endfunction

    task automatic flag_mismatch(string what, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Frame driver: pops pending frames, holds each until its transaction.
    // The prediction is taken at the accepting edge, from the driven ports.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_positions.push_back(
                    predict_position({s_sample_3, s_sample_2, s_sample_1, s_sample_0}));
                frames_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_frames.size() != 0 && !take_gap()) begin
                    next_frame = pending_frames.pop_front();
                    s_sample_0 <= next_frame[0];
                    s_sample_1 <= next_frame[1];
                    s_sample_2 <= next_frame[2];
                    s_sample_3 <= next_frame[3];
                    s_valid    <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Position monitor: in-order compare against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_positions.size() == 0) begin
                    flag_mismatch("position with no frame pending", '0, m_position_value);
                end else begin
                    oldest_position = expected_positions.pop_front();
                    if (m_position_value !== oldest_position)
                        flag_mismatch("position_value", oldest_position, m_position_value);
                end
            end
            m_ready <= !hold_off && !take_gap();
        end
    end

    // long receiver hold-off while the sender keeps offering frames,
    // so the pipe fills and s_ready has to drop
    initial begin
        while (frames_accepted < HOLD_AT) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // watchdog: too long without any transaction on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sensor_array_peak_interpolator test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration writes (only with the pipe empty)
    // ------------------------------------------------------------------------
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_THR_0: thr_q[0] = 32'(data);
            CFG_THR_1: thr_q[1] = 32'(data);
            CFG_THR_2: thr_q[2] = 32'(data);
            CFG_THR_3: thr_q[3] = 32'(data);
            CFG_BASE:  base_q   = 32'(data[VALUE_W-1:0]);
            CFG_TOP:   top_q    = 32'(data[VALUE_W-1:0]);
            CFG_SPAN:  span_q   = 32'(data[VALUE_W-1:0]);
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(slot_vec_t thr, int unsigned base, int unsigned top,
                                  int unsigned span);
        write_register(CFG_THR_0, thr[0]);
        write_register(CFG_THR_1, thr[1]);
        write_register(CFG_THR_2, thr[2]);
        write_register(CFG_THR_3, thr[3]);
        write_register(CFG_BASE, SAMPLE_W'(base));
        write_register(CFG_TOP,  SAMPLE_W'(top));
        write_register(CFG_SPAN, SAMPLE_W'(span));
    endtask

    // 7-bit value, extremes a good part of the time
    function automatic int unsigned pick_value();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 127;
            default: return $urandom_range(127);
        endcase
    endfunction

    // one ceiling per phase; mostly low so neighbors do count
    task automatic random_settings();
        slot_vec_t   thr;
        int unsigned ceiling;
        case ($urandom_range(5))
            0:       ceiling = 0;
            1, 2:    ceiling = 255;
            3:       ceiling = 4095;
            4:       ceiling = 32767;
            default: ceiling = 65535;
        endcase
        for (int i = 0; i < SLOT_COUNT; i++) thr[i] = SAMPLE_W'($urandom_range(ceiling));
        apply_settings(thr, pick_value(), pick_value(), pick_value());
    endtask

    // ------------------------------------------------------------------------
    // Frame generation
    // ------------------------------------------------------------------------
    function automatic slot_vec_t frame_of(int unsigned s0, int unsigned s1,
                                          int unsigned s2, int unsigned s3);
        return {SAMPLE_W'(s3), SAMPLE_W'(s2), SAMPLE_W'(s1), SAMPLE_W'(s0)};
    endfunction

    task automatic queue_frame(slot_vec_t f);
        pending_frames.push_back(f);
        frames_issued++;
    endtask

    // a clear peak on a random string, the rest at or below it
    function automatic slot_vec_t peaked_frame();
        slot_vec_t   f;
        int unsigned pk;
        int unsigned peak;
        pk   = $urandom_range(STRING_COUNT - 1);
        peak = $urandom_range(65535, 1);
        for (int i = 0; i < SLOT_COUNT; i++) f[i] = SAMPLE_W'($urandom_range(peak));
        f[pk] = SAMPLE_W'(peak);
        return f;
    endfunction

    // samples right at or just above the current thresholds
    function automatic slot_vec_t threshold_edge_frame();
        slot_vec_t   f;
        int unsigned v;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            v = thr_q[i] + $urandom_range(1);
            f[i] = (v > 65535) ? 16'hFFFF : SAMPLE_W'(v);
        end
        return f;
    endfunction

    function automatic slot_vec_t shaped_frame();
        slot_vec_t   f;
        int unsigned pick;
        int unsigned a;
        int unsigned b;
        pick = $urandom_range(99);
        if (pick < 65) begin
            f = peaked_frame();
        end else if (pick < 80) begin
            f = threshold_edge_frame();
        end else if (pick < 90) begin
            // one or two strings forced to the maximum, tying for strongest when two
            f    = peaked_frame();
            a    = $urandom_range(STRING_COUNT - 1);
            b    = $urandom_range(STRING_COUNT - 1);
            f[b] = 16'hFFFF;
            f[a] = 16'hFFFF;
        end else begin
            for (int i = 0; i < SLOT_COUNT; i++) f[i] = SAMPLE_W'($urandom_range(65535));
        end
        return f;
    endfunction

    // corners: nothing pressed, ties, each string as peak, end strings alone
    // and with a neighbor, smallest and largest peaks
    task automatic queue_directed();
        queue_frame(frame_of(0, 0, 0, 0));
        queue_frame(frame_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_frame(frame_of(1000, 0, 0, 0));
        queue_frame(frame_of(1000, 500, 0, 0));
        queue_frame(frame_of(0, 1000, 0, 0));
        queue_frame(frame_of(300, 1000, 700, 0));
        queue_frame(frame_of(0, 300, 1000, 700));
        queue_frame(frame_of(0, 0, 300, 1000));
        queue_frame(frame_of(0, 0, 0, 16'hFFFF));
        queue_frame(frame_of(0, 0, 16'hFFFF, 16'hFFFF));
        queue_frame(frame_of(5, 16'hFFFF, 16'hFFFF, 5));
        queue_frame(frame_of(1, 0, 0, 0));
        queue_frame(frame_of(16'hFFFF, 16'hFFFE, 1, 0));
        queue_frame(frame_of(0, 0, 1, 16'hFFFF));
    endtask

    // everything accepted and answered, then let the pipe settle
    task automatic wait_until_drained();
        while (frames_accepted != frames_issued || expected_positions.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        while (!aresetn) @(posedge aclk);
        @(posedge aclk);

        // reset settings
        queue_directed();
        wait_until_drained();

        // base at max, top at zero: the last string wraps below zero
        apply_settings(frame_of(0, 0, 0, 0), 127, 0, 127);
        queue_directed();
        wait_until_drained();

        // thresholds at max, zero span: nothing can ever be pressed
        apply_settings(frame_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 127, 127, 0);
        repeat (30) queue_frame(shaped_frame());
        wait_until_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_settings();
            repeat (PHASE_FRAMES) queue_frame(shaped_frame());
            wait_until_drained();
        end

        if (mismatches == 0)
            $display("sensor_array_peak_interpolator test passed");
        else
            $display("sensor_array_peak_interpolator test failed");
        $finish;
    end

endmodule
